>>> src/wfbd_pkg.sv
// Shared types, codes and sizes for the weather frame BCD decoder.
`default_nettype none

package wfbd_pkg;

	localparam int STORE_BYTES = 8;
	localparam int STORE_IDX_W = $clog2(STORE_BYTES);

	localparam logic [7:0] SYNC_BYTE  = 8'hFF;
	localparam logic [7:0] TYPE_WIND  = 8'h00;
	localparam logic [7:0] TYPE_RAIN  = 8'h01;
	localparam logic [7:0] TYPE_OUT   = 8'h03;
	localparam logic [7:0] TYPE_IN    = 8'h06;
	localparam logic [7:0] TYPE_CLOCK = 8'h0E;

	localparam logic [3:0] LEN_WIND = 4'd7;
	localparam logic [3:0] LEN_RAIN = 4'd12;
	localparam logic [3:0] LEN_OUT  = 4'd5;
	localparam logic [3:0] LEN_IN   = 4'd10;

	localparam logic [1:0] RANGE_BAD = 2'b01;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'b0001,
		PH_SYNC2 = 4'b0010,
		PH_TYPE  = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		K_WIND    = 3'd0,
		K_RAIN    = 3'd1,
		K_OUT     = 3'd2,
		K_IN      = 3'd3,
		K_CLOCK   = 3'd4,
		K_UNKNOWN = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_RANGE   = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef logic [14:0] value_t;

	// pending result between byte capture and output register
	typedef struct packed {
		logic    valid;
		logic    decode;
		kind_t   kind;
		status_t status;
	} req_t;

endpackage

`default_nettype wire

>>> src/weather_frame_bcd_decoder.sv
// Weather frame BCD decoder: sync hunt, payload capture and decimal decode.
// Result path: a frame's result is registered in a pending request stage once its last beat is
// accepted, and moves into the output registers whenever the output is not stalled.
// Throughput: one byte beat per cycle; input stalls only while the result path is full.
// Reset: hunts for the first sync byte, no result pending; payload store is not cleared.
`default_nettype none

module weather_frame_bcd_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       frame_kind,
	output logic [1:0]       status,
	output logic [14:0]      value_a,
	output logic [14:0]      value_b,
	output logic [14:0]      value_c,
	output logic [14:0]      value_d
);

	wfbd_pkg::phase_t phase_q, phase_d;
	wfbd_pkg::kind_t  kind_q, kind_d;
	logic [3:0]       left_q, left_d;
	logic [3:0]       index_q, index_d;
	logic [7:0]       store_q [wfbd_pkg::STORE_BYTES];
	logic             store_we;

	wfbd_pkg::req_t   req_s1, req_d;

	logic             out_valid_q;
	wfbd_pkg::kind_t  kind_s2;
	wfbd_pkg::status_t status_s2;
	wfbd_pkg::value_t val_a_s2, val_b_s2, val_c_s2, val_d_s2;

	logic             advance;
	logic             accept;
	logic [3:0]       left_dec;

	wfbd_pkg::status_t dec_status;
	wfbd_pkg::value_t  dec_a, dec_b, dec_c, dec_d;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = req_s1.valid && !advance;
	assign accept   = in_valid && !in_stall;
	assign left_dec = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;

	// frame tracking
	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		left_d   = left_q;
		index_d  = index_q;
		store_we = 1'b0;
		req_d    = '{valid: 1'b0, decode: 1'b0, kind: wfbd_pkg::K_WIND,
			status: wfbd_pkg::ST_OK};
		unique case (phase_q)
			wfbd_pkg::PH_SYNC2: begin
				phase_d = (rx_byte == wfbd_pkg::SYNC_BYTE) ? wfbd_pkg::PH_TYPE
					: wfbd_pkg::PH_HUNT;
			end
			wfbd_pkg::PH_TYPE: begin
				phase_d = wfbd_pkg::PH_DATA;
				index_d = 4'd0;
				priority if (rx_byte == wfbd_pkg::TYPE_WIND) begin
					kind_d = wfbd_pkg::K_WIND;
					left_d = wfbd_pkg::LEN_WIND;
				end else if (rx_byte == wfbd_pkg::TYPE_RAIN) begin
					kind_d = wfbd_pkg::K_RAIN;
					left_d = wfbd_pkg::LEN_RAIN;
				end else if (rx_byte == wfbd_pkg::TYPE_OUT) begin
					kind_d = wfbd_pkg::K_OUT;
					left_d = wfbd_pkg::LEN_OUT;
				end else if (rx_byte == wfbd_pkg::TYPE_IN) begin
					kind_d = wfbd_pkg::K_IN;
					left_d = wfbd_pkg::LEN_IN;
				end else if (rx_byte == wfbd_pkg::TYPE_CLOCK) begin
					phase_d = wfbd_pkg::PH_HUNT;
					index_d = index_q;
					req_d   = '{valid: 1'b1, decode: 1'b0, kind: wfbd_pkg::K_CLOCK,
						status: wfbd_pkg::ST_OK};
				end else begin
					phase_d = wfbd_pkg::PH_HUNT;
					index_d = index_q;
					req_d   = '{valid: 1'b1, decode: 1'b0, kind: wfbd_pkg::K_UNKNOWN,
						status: wfbd_pkg::ST_UNKNOWN};
				end
			end
			wfbd_pkg::PH_DATA: begin
				store_we = (32'(index_q) < wfbd_pkg::STORE_BYTES);
				index_d  = index_q + 4'd1;
				left_d   = left_dec;
				if (left_dec == 4'd0) begin
					phase_d = wfbd_pkg::PH_HUNT;
					req_d   = '{valid: 1'b1, decode: 1'b1, kind: kind_q,
						status: wfbd_pkg::ST_OK};
				end
			end
			default: begin
				phase_d = (rx_byte == wfbd_pkg::SYNC_BYTE) ? wfbd_pkg::PH_SYNC2
					: wfbd_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wfbd_pkg::PH_HUNT;
			kind_q  <= wfbd_pkg::K_WIND;
			left_q  <= 4'd0;
			index_q <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			left_q  <= left_d;
			index_q <= index_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_we) begin
			store_q[index_q[wfbd_pkg::STORE_IDX_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '{valid: 1'b0, decode: 1'b0, kind: wfbd_pkg::K_WIND,
				status: wfbd_pkg::ST_OK};
		end else if (accept && req_d.valid) begin
			req_s1 <= req_d;
		end else if (advance) begin
			req_s1.valid <= 1'b0;
		end
	end

	// decimal decode of the completed payload
	always_comb begin
		logic [3:0] lo1, hi1, lo2, hi2, lo3, hi3, lo4, hi4, lo5, hi5, lo6, hi6;
		logic [7:0] checked;
		lo1 = store_q[1][3:0]; hi1 = store_q[1][7:4];
		lo2 = store_q[2][3:0]; hi2 = store_q[2][7:4];
		lo3 = store_q[3][3:0]; hi3 = store_q[3][7:4];
		lo4 = store_q[4][3:0]; hi4 = store_q[4][7:4];
		lo5 = store_q[5][3:0]; hi5 = store_q[5][7:4];
		lo6 = store_q[6][3:0]; hi6 = store_q[6][7:4];
		checked = (req_s1.kind == wfbd_pkg::K_OUT) ? store_q[2] : store_q[1];
		dec_status = wfbd_pkg::ST_OK;
		dec_a = '0;
		dec_b = '0;
		dec_c = '0;
		dec_d = '0;
		priority if (checked == 8'd0) begin
			dec_status = wfbd_pkg::ST_EMPTY;
		end else if (req_s1.kind == wfbd_pkg::K_WIND) begin
			dec_a = 15'(lo2) * 15'd100 + 15'(hi1) * 15'd10 + 15'(lo1);
			dec_b = 15'(hi3) * 15'd10 + 15'(lo3) + 15'(hi2 >= 4'd10);
			dec_c = 15'(lo5) * 15'd10 + 15'(hi4) + 15'(lo4 >= 4'd10);
			dec_d = 15'(hi6) * 15'd10 + 15'(lo6);
		end else if (req_s1.kind == wfbd_pkg::K_RAIN) begin
			dec_a = 15'(lo2) * 15'd100 + 15'(hi1) * 15'd10 + 15'(lo1);
			dec_b = 15'(hi4) * 15'd1000 + 15'(lo4) * 15'd100 + 15'(hi3) * 15'd10
				+ 15'(lo3) + 15'(hi2 >= 4'd10);
			dec_c = 15'(hi6) * 15'd1000 + 15'(lo6) * 15'd100 + 15'(hi5) * 15'd10
				+ 15'(lo5);
		end else if (store_q[2][7:6] == wfbd_pkg::RANGE_BAD) begin
			dec_status = wfbd_pkg::ST_RANGE;
		end else begin
			dec_a = 15'(hi2) * 15'd100 + 15'(lo2) * 15'd10 + 15'(hi1)
				+ 15'(lo1 >= 4'd10);
			dec_b = 15'(hi3) * 15'd10 + 15'(lo3);
			dec_c = 15'(hi4) * 15'd10 + 15'(lo4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= req_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_s1.valid) begin
			kind_s2 <= req_s1.kind;
			if (req_s1.decode) begin
				status_s2 <= dec_status;
				val_a_s2  <= dec_a;
				val_b_s2  <= dec_b;
				val_c_s2  <= dec_c;
				val_d_s2  <= dec_d;
			end else begin
				status_s2 <= req_s1.status;
				val_a_s2  <= '0;
				val_b_s2  <= '0;
				val_c_s2  <= '0;
				val_d_s2  <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_kind = kind_s2;
	assign status     = status_s2;
	assign value_a    = val_a_s2;
	assign value_b    = val_b_s2;
	assign value_c    = val_c_s2;
	assign value_d    = val_d_s2;

endmodule

`default_nettype wire

>>> test/tb_weather_frame_bcd_decoder.sv
// Self-checking testbench for the weather frame BCD decoder: directed frames, random traffic.
`default_nettype none

module tb_weather_frame_bcd_decoder;

	typedef struct packed {
		wfbd_pkg::kind_t   kind;
		wfbd_pkg::status_t status;
		wfbd_pkg::value_t  a;
		wfbd_pkg::value_t  b;
		wfbd_pkg::value_t  c;
		wfbd_pkg::value_t  d;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  frame_kind;
	logic [1:0]  status;
	logic [14:0] value_a;
	logic [14:0] value_b;
	logic [14:0] value_c;
	logic [14:0] value_d;

	weather_frame_bcd_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_kind (frame_kind),
		.status     (status),
		.value_a    (value_a),
		.value_b    (value_b),
		.value_c    (value_c),
		.value_d    (value_d)
	);

	// predictor state
	wfbd_pkg::phase_t link_phase;
	wfbd_pkg::kind_t  held_kind;
	logic [3:0]       left_count;
	logic [3:0]       store_idx;
	logic [7:0]       byte_store [wfbd_pkg::STORE_BYTES];
	frame_result_t    pending_frames [$];

	int mismatches;
	int send_idle_pct;
	int recv_stall_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic int unsigned low_digit(int i);
		return byte_store[i][3:0];
	endfunction

	function automatic int unsigned high_digit(int i);
		return byte_store[i][7:4];
	endfunction

	function automatic frame_result_t decode_frame();
		frame_result_t r;
		logic [7:0]    checked;
		int unsigned   a, b, c, d;
		r = '0;
		a = 0;
		b = 0;
		c = 0;
		d = 0;
		r.kind = held_kind;
		r.status = wfbd_pkg::ST_OK;
		checked = (held_kind == wfbd_pkg::K_OUT) ? byte_store[2] : byte_store[1];
		if (checked == 8'h00) begin
			r.status = wfbd_pkg::ST_EMPTY;
		end else if (held_kind == wfbd_pkg::K_WIND) begin
			a = low_digit(2) * 100 + high_digit(1) * 10 + low_digit(1);
			b = high_digit(3) * 10 + low_digit(3) + high_digit(2) / 10;
			c = low_digit(5) * 10 + high_digit(4) + low_digit(4) / 10;
			d = high_digit(6) * 10 + low_digit(6);
		end else if (held_kind == wfbd_pkg::K_RAIN) begin
			a = low_digit(2) * 100 + high_digit(1) * 10 + low_digit(1);
			b = high_digit(4) * 1000 + low_digit(4) * 100 + high_digit(3) * 10
				+ low_digit(3) + high_digit(2) / 10;
			c = high_digit(6) * 1000 + low_digit(6) * 100 + high_digit(5) * 10
				+ low_digit(5);
		end else if (byte_store[2][7:6] == wfbd_pkg::RANGE_BAD) begin
			r.status = wfbd_pkg::ST_RANGE;
		end else begin
			a = high_digit(2) * 100 + low_digit(2) * 10 + high_digit(1) + low_digit(1) / 10;
			b = high_digit(3) * 10 + low_digit(3);
			c = high_digit(4) * 10 + low_digit(4);
		end
		r.a = wfbd_pkg::value_t'(a);
		r.b = wfbd_pkg::value_t'(b);
		r.c = wfbd_pkg::value_t'(c);
		r.d = wfbd_pkg::value_t'(d);
		return r;
	endfunction

	task automatic predict_beat(input logic [7:0] b);
		frame_result_t r;
		r = '0;
		case (link_phase)
			wfbd_pkg::PH_SYNC2: begin
				link_phase = (b == wfbd_pkg::SYNC_BYTE) ? wfbd_pkg::PH_TYPE
					: wfbd_pkg::PH_HUNT;
			end
			wfbd_pkg::PH_TYPE: begin
				link_phase = wfbd_pkg::PH_DATA;
				store_idx = '0;
				case (b)
					wfbd_pkg::TYPE_WIND: begin
						held_kind = wfbd_pkg::K_WIND;
						left_count = wfbd_pkg::LEN_WIND;
					end
					wfbd_pkg::TYPE_RAIN: begin
						held_kind = wfbd_pkg::K_RAIN;
						left_count = wfbd_pkg::LEN_RAIN;
					end
					wfbd_pkg::TYPE_OUT: begin
						held_kind = wfbd_pkg::K_OUT;
						left_count = wfbd_pkg::LEN_OUT;
					end
					wfbd_pkg::TYPE_IN: begin
						held_kind = wfbd_pkg::K_IN;
						left_count = wfbd_pkg::LEN_IN;
					end
					wfbd_pkg::TYPE_CLOCK: begin
						link_phase = wfbd_pkg::PH_HUNT;
						r.kind = wfbd_pkg::K_CLOCK;
						r.status = wfbd_pkg::ST_OK;
						pending_frames.push_back(r);
					end
					default: begin
						link_phase = wfbd_pkg::PH_HUNT;
						r.kind = wfbd_pkg::K_UNKNOWN;
						r.status = wfbd_pkg::ST_UNKNOWN;
						pending_frames.push_back(r);
					end
				endcase
			end
			wfbd_pkg::PH_DATA: begin
				if (32'(store_idx) < wfbd_pkg::STORE_BYTES)
					byte_store[store_idx[wfbd_pkg::STORE_IDX_W-1:0]] = b;
				store_idx = store_idx + 4'd1;
				if (left_count != 0)
					left_count = left_count - 4'd1;
				if (left_count == 0) begin
					link_phase = wfbd_pkg::PH_HUNT;
					pending_frames.push_back(decode_frame());
				end
			end
			default: begin
				link_phase = (b == wfbd_pkg::SYNC_BYTE) ? wfbd_pkg::PH_SYNC2
					: wfbd_pkg::PH_HUNT;
			end
		endcase
	endtask

	function automatic void check_field(string name, logic [14:0] want, logic [14:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// results are checked before the same edge's input beat is predicted
	always @(posedge clk) begin : frame_checker
		frame_result_t want;
		if (arst_n) begin
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_frames.size() == 0) begin
					$display("%0t: unexpected result, expected none actual kind %0d status %0d",
						$time, frame_kind, status);
					mismatches++;
				end else begin
					want = pending_frames.pop_front();
					check_field("frame_kind", 15'(want.kind), 15'(frame_kind));
					check_field("status", 15'(want.status), 15'(status));
					check_field("value_a", want.a, value_a);
					check_field("value_b", want.b, value_b);
					check_field("value_c", want.c, value_c);
					check_field("value_d", want.d, value_d);
				end
			end
			if (in_valid && !in_stall)
				predict_beat(rx_byte);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0)
			@(posedge clk);
	endtask

	function automatic int frame_len(logic [7:0] t);
		case (t)
			wfbd_pkg::TYPE_WIND: return wfbd_pkg::LEN_WIND;
			wfbd_pkg::TYPE_RAIN: return wfbd_pkg::LEN_RAIN;
			wfbd_pkg::TYPE_OUT:  return wfbd_pkg::LEN_OUT;
			wfbd_pkg::TYPE_IN:   return wfbd_pkg::LEN_IN;
			default:             return 0;
		endcase
	endfunction

	function automatic logic [7:0] payload_byte(logic [7:0] t, int pos);
		int sel;
		sel = $urandom_range(99);
		// lean on empty checked bytes, range flags and extreme nibbles
		if (pos == ((t == wfbd_pkg::TYPE_OUT) ? 2 : 1) && sel < 12)
			return 8'h00;
		if (pos == 2 && sel < 30)
			return {wfbd_pkg::RANGE_BAD, 6'($urandom)};
		if (sel < 40)
			return ($urandom_range(1) != 0) ? 8'hFF : 8'h99;
		return 8'($urandom);
	endfunction

	task automatic send_frame(input logic [7:0] t);
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(t);
		for (int i = 0; i < frame_len(t); i++)
			send_byte(payload_byte(t, i));
	endtask

	// returns the number of beats sent that are not plain hunt noise
	task automatic send_random_sequence(output int beats);
		int          sel;
		logic [7:0]  t;
		sel = $urandom_range(99);
		beats = 0;
		if (sel < 80) begin
			case ($urandom_range(9))
				0, 1:    t = wfbd_pkg::TYPE_WIND;
				2, 3:    t = wfbd_pkg::TYPE_RAIN;
				4, 5:    t = wfbd_pkg::TYPE_OUT;
				6, 7:    t = wfbd_pkg::TYPE_IN;
				8:       t = wfbd_pkg::TYPE_CLOCK;
				default: t = 8'($urandom);
			endcase
			send_frame(t);
			beats = 3 + frame_len(t);
		end else if (sel < 90) begin
			send_byte(wfbd_pkg::SYNC_BYTE);
			send_byte(8'($urandom_range(8'hFE)));
			beats = 2;
		end else if (sel < 95) begin
			send_byte(wfbd_pkg::SYNC_BYTE);
			send_byte(wfbd_pkg::SYNC_BYTE);
			send_byte(wfbd_pkg::SYNC_BYTE);
			beats = 3;
		end else begin
			send_byte(8'($urandom_range(8'hFE)));
		end
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_byte(8'h00);
		// missing second sync
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(8'h12);
		send_frame(wfbd_pkg::TYPE_CLOCK);
		// sync byte taken as a type
		send_frame(wfbd_pkg::SYNC_BYTE);
		// outdoor thermo, temperature out of range
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(wfbd_pkg::TYPE_OUT);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h40);
		send_byte(8'hFF);
		send_byte(8'h00);
		// outdoor thermo, empty checked byte
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(wfbd_pkg::SYNC_BYTE);
		send_byte(wfbd_pkg::TYPE_OUT);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		go_quiet();
		wait_drained();
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall_pct, input int n);
		int sent;
		int beats;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n) begin
			send_random_sequence(beats);
			sent += beats;
		end
		go_quiet();
		wait_drained();
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		recv_stall_pct = 81;
		send_frame(wfbd_pkg::TYPE_CLOCK);
		send_frame(wfbd_pkg::TYPE_WIND);
		send_frame(8'h07);
		go_quiet();
		wait_drained();
		send_frame(wfbd_pkg::TYPE_IN);
		send_frame(wfbd_pkg::TYPE_CLOCK);
		go_quiet();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		link_phase = wfbd_pkg::PH_HUNT;
		held_kind = wfbd_pkg::K_WIND;
		left_count = '0;
		store_idx = '0;
		for (int i = 0; i < wfbd_pkg::STORE_BYTES; i++)
			byte_store[i] = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_frames(0, 0, 320);
		test_random_frames(81, 0, 320);
		test_random_frames(0, 81, 320);
		test_random_frames(38, 38, 320);
		test_drain_pause();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
